[src/gcsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcsa_pkg;

  // Item kinds
  localparam logic [1:0] KIND_ACCUMULATE = 2'd0;
  localparam logic [1:0] KIND_READ       = 2'd1;
  localparam logic [1:0] KIND_CLEAR      = 2'd2;

  // Configuration register indexes
  localparam logic CFG_NUM_COLS = 1'b0;
  localparam logic CFG_NUM_ROWS = 1'b1;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PROD_W  = COORD_W + CFG_W;
  localparam int unsigned SUM_W   = PROD_W + 1;

  // One cell entry of the statistics memory
  typedef struct packed {
    logic               occupied;
    logic [63:0]        sq;
    logic signed [63:0] sum;
    logic signed [31:0] max_v;
    logic signed [31:0] min_v;
    logic [31:0]        count;
  } cell_t;

  localparam int unsigned CELL_W = $bits(cell_t);

endpackage

`default_nettype wire

[src/grid_cell_statistics_accumulator.sv]
// Grid cell statistics accumulator. Each input beat addresses one grid cell
// (row * num_cols + col) and accumulates a Q20.12 point, reads the cell, or
// clears it; every beat yields exactly one output beat with the cell's
// statistics after the operation, or bad_address with all other fields zero.
// All cell state lives in one synchronous RAM of CELL_COUNT entries. After
// reset the block sweeps that RAM to zero, one entry per cycle, so input is
// stalled until the sweep ends (configuration writes are taken throughout).
// Items are handled one at a time, each through the read-modify-write of the
// cell RAM: address multiply and squaring, RAM read, update and write back
// (update skipped for a bad address), then handoff to the output register.
// The output register lets a new beat be accepted while the previous result
// is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_statistics_accumulator
  import gcsa_pkg::*;
#(
  parameter int unsigned CELL_COUNT = 4096,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic [COORD_W-1:0] col,
  input  wire logic signed [31:0] sample_value,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             point_count,
  output logic signed [31:0]      min_value,
  output logic signed [31:0]      max_value,
  output logic signed [63:0]      value_sum,
  output logic [63:0]             square_sum,
  output logic                    has_points,
  output logic                    bad_address
);

  localparam int unsigned ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [SUM_W-1:0]  CELL_LIMIT = SUM_W'(CELL_COUNT);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CALC,
    S_LOOK,
    S_UPD,
    S_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   num_cols;
  logic [CFG_W-1:0]   num_rows;

  logic [ADDR_W-1:0]  clr_idx;
  logic [1:0]         kind_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic signed [31:0] value_q;
  logic               bad_rc;
  logic [PROD_W-1:0]  prod;
  logic [63:0]        square;
  logic [ADDR_W-1:0]  addr_q;
  cell_t              res_cell;
  logic               res_bad;

  logic [31:0]        mag;
  logic [SUM_W-1:0]   addr_sum;
  logic               addr_bad;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  cell_t              ram_wdata;
  cell_t              ram_rdata;
  cell_t              upd_cell;
  logic               upd_we;
  logic               out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= CFG_W'(64);
      num_rows <= CFG_W'(64);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NUM_COLS: num_cols <= cfg_data;
        CFG_NUM_ROWS: num_rows <= cfg_data;
        default:      num_cols <= num_cols;
      endcase
    end
  end

  // Combinational address and magnitude
  assign mag      = value_q[31] ? (32'd0 - value_q) : value_q;
  assign addr_sum = {1'b0, prod} + SUM_W'(col_q);
  assign addr_bad = bad_rc || (addr_sum >= CELL_LIMIT);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Cell update datapath
  gcsa_update u_update (
    .kind     (kind_q),
    .value    (value_q),
    .square   (square),
    .old_cell (ram_rdata),
    .new_cell (upd_cell),
    .write_en (upd_we)
  );

  // RAM write side: clearing sweep or write back
  always_comb begin
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_UPD) && upd_we;
      ram_waddr = addr_q;
      ram_wdata = upd_cell;
    end
  end

  gcsa_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_sum[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + ADDR_W'(1);
          if (clr_idx == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_q  <= kind;
            row_q   <= row;
            col_q   <= col;
            value_q <= 32'($signed(sample_value[VALUE_BITS-1:0]));
            state   <= S_CALC;
          end
        end
        S_CALC: begin
          bad_rc <= (CFG_W'(row_q) >= num_rows) || (CFG_W'(col_q) >= num_cols);
          prod   <= PROD_W'(row_q) * PROD_W'(num_cols);
          square <= 64'(mag) * 64'(mag);
          state  <= S_LOOK;
        end
        S_LOOK: begin
          addr_q <= addr_sum[ADDR_W-1:0];
          if (addr_bad) begin
            res_cell <= '0;
            res_bad  <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          res_cell <= upd_cell;
          res_bad  <= 1'b0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            point_count <= res_cell.count;
            min_value   <= res_cell.occupied ? res_cell.min_v : 32'sd0;
            max_value   <= res_cell.occupied ? res_cell.max_v : 32'sd0;
            value_sum   <= res_cell.sum;
            square_sum  <= res_cell.sq;
            has_points  <= res_cell.occupied;
            bad_address <= res_bad;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // No input beat is taken during the clearing sweep
  assert property (@(posedge clk) disable iff (rst) (state == S_CLR) |-> in_stall)
    else $error("input accepted during clearing sweep");

  // RAM is written only by the sweep or the update step
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLR || state == S_UPD))
    else $error("unexpected RAM write");

  // A new result is loaded only from the handoff state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside handoff");

  // A bad address result carries no statistics
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_address) |-> (point_count == 32'd0 && !has_points
      && value_sum == 64'sd0 && square_sum == 64'd0))
    else $error("bad address result not zeroed");

  // An empty cell reports zero min and max
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_points) |-> (min_value == 32'sd0 && max_value == 32'sd0))
    else $error("empty cell reports min or max");
`endif

endmodule

`default_nettype wire

[src/gcsa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/gcsa_update.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcsa_update
  import gcsa_pkg::*;
(
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] value,
  input  wire logic [63:0]        square,
  input  wire cell_t              old_cell,
  output cell_t                   new_cell,
  output logic                    write_en
);

  logic [64:0] sum_wide;
  logic [64:0] sq_wide;
  cell_t       acc_cell;

  // Widened sums for saturation
  assign sum_wide = {old_cell.sum[63], old_cell.sum} + {{33{value[31]}}, value};
  assign sq_wide  = {1'b0, old_cell.sq} + {1'b0, square};

  // Fold one point into the cell
  always_comb begin
    acc_cell = old_cell;
    if (old_cell.count != '1) begin
      acc_cell.count = old_cell.count + 32'd1;
    end
    if (sum_wide[64] != sum_wide[63]) begin
      acc_cell.sum = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_cell.sum = sum_wide[63:0];
    end
    acc_cell.sq = sq_wide[64] ? '1 : sq_wide[63:0];
    if (!old_cell.occupied) begin
      acc_cell.min_v    = value;
      acc_cell.max_v    = value;
      acc_cell.occupied = 1'b1;
    end else begin
      if ($signed(value) < $signed(old_cell.min_v)) begin
        acc_cell.min_v = value;
      end
      if ($signed(value) > $signed(old_cell.max_v)) begin
        acc_cell.max_v = value;
      end
    end
  end

  // Select the new entry by kind
  always_comb begin
    case (kind)
      KIND_ACCUMULATE: begin
        new_cell = acc_cell;
        write_en = 1'b1;
      end
      KIND_CLEAR: begin
        new_cell = '0;
        write_en = 1'b1;
      end
      default: begin
        new_cell = old_cell;
        write_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[verif/tb_grid_cell_statistics_accumulator.sv]
`timescale 1ns / 1ps

module tb_grid_cell_statistics_accumulator;
  import gcsa_pkg::*;

  localparam int unsigned CELLS = 4096;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0000_1000;
  localparam int unsigned LONG_HOLD = 200;

  // One cell report as the block presents it
  typedef struct packed {
    logic [31:0]        count;
    logic signed [31:0] min_v;
    logic signed [31:0] max_v;
    logic signed [63:0] sum;
    logic [63:0]        sq;
    logic               has;
    logic               bad;
  } cell_report_t;

  // Shadow copy of the grid: predicts the report of every accepted beat and
  // compares the block's reports against them in order.
  class cell_stats_scoreboard;
    logic [31:0]        tally     [CELLS];
    logic signed [31:0] low_mark  [CELLS];
    logic signed [31:0] high_mark [CELLS];
    logic signed [63:0] run_sum   [CELLS];
    logic [63:0]        run_sq    [CELLS];
    bit                 occupied  [CELLS];
    logic [CFG_W-1:0]   grid_cols;
    logic [CFG_W-1:0]   grid_rows;
    cell_report_t       expected_reports[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      grid_cols = 13'd64;
      grid_rows = 13'd64;
      foreach (tally[i]) begin
        tally[i] = '0;
        low_mark[i] = '0;
        high_mark[i] = '0;
        run_sum[i] = '0;
        run_sq[i] = '0;
        occupied[i] = 1'b0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_grid_register(logic index, logic [CFG_W-1:0] value);
      if (index == CFG_NUM_COLS) grid_cols = value;
      else grid_rows = value;
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction

    // Apply one accepted beat to the shadow grid and queue its report
    function void predict_cell_item(logic [1:0] k, logic [11:0] r, logic [11:0] c,
                                    logic signed [31:0] v);
      cell_report_t       want;
      longint unsigned    addr;
      int                 slot;
      longint             wide_v;
      logic [63:0]        mag;
      logic [63:0]        sqv;
      logic signed [64:0] wide_sum;
      logic [64:0]        wide_sq;
      want = '0;
      addr = longint'(r) * grid_cols + c;
      if (r >= grid_rows || c >= grid_cols || addr >= CELLS) begin
        want.bad = 1'b1;
        expected_reports.push_back(want);
        return;
      end
      slot = int'(addr);
      if (k == KIND_ACCUMULATE) begin
        if (tally[slot] != 32'hFFFF_FFFF) tally[slot] = tally[slot] + 1;
        // saturate the sum when the sign of the 65-bit result disagrees
        wide_sum = run_sum[slot] + v;
        if (wide_sum[64] != wide_sum[63])
          run_sum[slot] = wide_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
          run_sum[slot] = wide_sum[63:0];
        wide_v = v;
        mag = (wide_v < 0) ? -wide_v : wide_v;
        sqv = mag * mag;
        wide_sq = run_sq[slot] + sqv;
        run_sq[slot] = wide_sq[64] ? '1 : wide_sq[63:0];
        if (!occupied[slot]) begin
          low_mark[slot] = v;
          high_mark[slot] = v;
          occupied[slot] = 1'b1;
        end else begin
          if (v < low_mark[slot]) low_mark[slot] = v;
          if (v > high_mark[slot]) high_mark[slot] = v;
        end
      end else if (k == KIND_CLEAR) begin
        tally[slot] = '0;
        low_mark[slot] = '0;
        high_mark[slot] = '0;
        run_sum[slot] = '0;
        run_sq[slot] = '0;
        occupied[slot] = 1'b0;
      end
      want.count = tally[slot];
      if (occupied[slot]) begin
        want.min_v = low_mark[slot];
        want.max_v = high_mark[slot];
        want.has = 1'b1;
      end
      want.sum = run_sum[slot];
      want.sq = run_sq[slot];
      expected_reports.push_back(want);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] error: report %0d %s: got %h, expected %h",
               $time, checked, what, got, want);
    endtask

    // Compare one output beat with the oldest queued report
    task check_cell_report(cell_report_t got);
      cell_report_t want;
      checked++;
      if (expected_reports.size() == 0) begin
        report_mismatch("arrived with nothing queued", '0, '0);
        return;
      end
      want = expected_reports.pop_front();
      if (got.count !== want.count) report_mismatch("point_count", got.count, want.count);
      if (got.min_v !== want.min_v) report_mismatch("min_value", got.min_v, want.min_v);
      if (got.max_v !== want.max_v) report_mismatch("max_value", got.max_v, want.max_v);
      if (got.sum !== want.sum) report_mismatch("value_sum", got.sum, want.sum);
      if (got.sq !== want.sq) report_mismatch("square_sum", got.sq, want.sq);
      if (got.has !== want.has) report_mismatch("has_points", got.has, want.has);
      if (got.bad !== want.bad) report_mismatch("bad_address", got.bad, want.bad);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic                      cfg_index = CFG_NUM_COLS;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                kind = KIND_READ;
  logic [COORD_W-1:0]        row = '0;
  logic [COORD_W-1:0]        col = '0;
  logic signed [31:0]        sample_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b1;
  logic [31:0]               point_count;
  logic signed [31:0]        min_value;
  logic signed [31:0]        max_value;
  logic signed [63:0]        value_sum;
  logic [63:0]               square_sum;
  logic                      has_points;
  logic                      bad_address;

  cell_stats_scoreboard sb = new();
  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 1;
  int unsigned cur_cols = 64;
  int unsigned cur_rows = 64;

  grid_cell_statistics_accumulator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .row          (row),
    .col          (col),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_count  (point_count),
    .min_value    (min_value),
    .max_value    (max_value),
    .value_sum    (value_sum),
    .square_sum   (square_sum),
    .has_points   (has_points),
    .bad_address  (bad_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one input beat after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] k, input logic [11:0] r, input logic [11:0] c,
                           input logic [31:0] v);
    int unsigned gap;
    gap = (((sent_count / 90) % 4) == 1) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= k;
    row <= r;
    col <= c;
    sample_value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.predict_cell_item(k, r, c, v);
    sent_count++;
  endtask

  // Drop valid and wait until every queued report has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    sb.set_grid_register(index, value);
  endtask

  // Change grid shape between phases, only with the block idle
  task automatic reshape_grid(input int unsigned cols, input int unsigned rows);
    wait_drained();
    write_register(CFG_NUM_COLS, CFG_W'(cols));
    write_register(CFG_NUM_ROWS, CFG_W'(rows));
    cfg_write <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
    settings_used++;
  endtask

  // Random beats aimed mostly at a small hot set of valid cells
  task automatic run_random(input int unsigned n);
    logic [1:0]  k;
    logic [11:0] r;
    logic [11:0] c;
    logic [31:0] v;
    int unsigned pick;
    int unsigned limit;
    int unsigned a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) k = KIND_ACCUMULATE;
      else if (pick < 82) k = KIND_READ;
      else if (pick < 93) k = KIND_CLEAR;
      else k = KIND_UNKNOWN;
      if (cur_cols != 0 && cur_rows != 0 && $urandom_range(0, 99) < 85) begin
        limit = cur_cols * cur_rows - 1;
        if (limit > CELLS - 1) limit = CELLS - 1;
        if ($urandom_range(0, 99) < 70) a = $urandom_range(0, (limit < 31) ? limit : 31);
        else a = $urandom_range(0, limit);
        r = 12'(a / cur_cols);
        c = 12'(a % cur_cols);
      end else begin
        r = 12'($urandom_range(0, 4095));
        c = 12'($urandom_range(0, 4095));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) v = $urandom();
      else if (pick < 80) v = 32'($urandom_range(0, 131072)) - 32'h0001_0000;
      else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end else v = $urandom() >> $urandom_range(0, 31);
      send_item(k, r, c, v);
    end
  endtask

  // Receiver: random stalls, one long hold-off, check every output beat
  initial begin : collect_reports
    int unsigned  gap;
    bit           held;
    cell_report_t seen;
    held = 1'b0;
    forever begin
      if (!held && results_seen == 500) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = (((results_seen / 110) % 5) == 3) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      seen.count = point_count;
      seen.min_v = min_value;
      seen.max_v = max_value;
      seen.sum = value_sum;
      seen.sq = square_sum;
      seen.has = has_points;
      seen.bad = bad_address;
      sb.check_cell_report(seen);
      results_seen++;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default 64 x 64 grid: empty cell, extremes, square-sum saturation
    send_item(KIND_READ, 12'd0, 12'd0, Q_ONE);
    send_item(KIND_ACCUMULATE, 12'd0, 12'd0, Q_MAX);
    repeat (4) send_item(KIND_ACCUMULATE, 12'd0, 12'd0, Q_MIN);
    send_item(KIND_UNKNOWN, 12'd0, 12'd0, Q_MAX);
    send_item(KIND_CLEAR, 12'd0, 12'd0, Q_MAX);
    send_item(KIND_READ, 12'd0, 12'd0, '0);
    send_item(KIND_ACCUMULATE, 12'd63, 12'd63, '1);
    send_item(KIND_ACCUMULATE, 12'd63, 12'd63, Q_ONE);
    // out-of-range row, column and both
    send_item(KIND_ACCUMULATE, 12'd64, 12'd0, Q_ONE);
    send_item(KIND_CLEAR, 12'd0, 12'd64, Q_ONE);
    send_item(KIND_UNKNOWN, 12'd4095, 12'd4095, Q_MIN);
    // clear a cell that never held a point
    send_item(KIND_CLEAR, 12'd5, 12'd5, '0);
    run_random(400);

    // Single column, full height
    reshape_grid(1, 4096);
    send_item(KIND_ACCUMULATE, 12'd4095, 12'd0, Q_MIN);
    send_item(KIND_ACCUMULATE, 12'd0, 12'd1, Q_ONE);
    run_random(200);

    // Single row, full width
    reshape_grid(4096, 1);
    send_item(KIND_ACCUMULATE, 12'd0, 12'd4095, '0);
    send_item(KIND_READ, 12'd1, 12'd0, '0);
    run_random(150);

    // Row and column in range, address at the last cell and past the store
    reshape_grid(4096, 4096);
    send_item(KIND_READ, 12'd0, 12'd4095, '0);
    send_item(KIND_ACCUMULATE, 12'd1, 12'd0, Q_MAX);
    run_random(200);

    // Zero-sized grids flag everything
    reshape_grid(0, 64);
    run_random(30);
    reshape_grid(64, 0);
    run_random(20);

    // Register top values
    reshape_grid(8191, 8191);
    send_item(KIND_READ, 12'd0, 12'd4095, '0);
    send_item(KIND_READ, 12'd1, 12'd0, '0);
    run_random(150);

    reshape_grid($urandom_range(2, 90), $urandom_range(2, 90));
    run_random(250);

    // Back to the reset shape: cells filled earlier are still there
    reshape_grid(64, 64);
    run_random(300);

    // Let stray beats show up after the last expected report
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run summary: %0d input beats over %0d grid shapes, %0d reports checked.",
             sent_count, settings_used, sb.checked);
    $display("Mismatches found: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: %0d reports still queued", sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
